// File: src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while rst_n is low.
`define TCQD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold whenever a result is on offer.
`define TCQD_ASSERT_VALID(lbl, cond, msg) \
  `TCQD_ASSERT(lbl, out_tvalid |-> (cond), msg)

`endif

// File: src/tcqd_pkg.sv
package tcqd_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_TX_SIZE = 3'd0;
  localparam logic [2:0] REG_ZBIN    = 3'd1;
  localparam logic [2:0] REG_ROUND   = 3'd2;
  localparam logic [2:0] REG_QUANT   = 3'd3;
  localparam logic [2:0] REG_SHIFT   = 3'd4;
  localparam logic [2:0] REG_DEQUANT = 3'd5;

  localparam logic [1:0] TX_4X4   = 2'd0;
  localparam logic [1:0] TX_8X8   = 2'd1;
  localparam logic [1:0] TX_16X16 = 2'd2;
  localparam logic [1:0] TX_32X32 = 2'd3;

  localparam int MAX_COUNT = 1024;

  typedef struct packed {
    logic [1:0]  tx_size;
    logic [31:0] zbin_pair;
    logic [31:0] round_pair;
    logic [31:0] quant_pair;
    logic [31:0] shift_pair;
    logic [31:0] dequant_pair;
  } cfg_t;

  // One classified coefficient as held in the queue
  typedef struct packed {
    logic signed [15:0] coef;
    logic               ac;
    logic               last;
  } queue_item_t;

  // Side information carried down the back-end pipeline
  typedef struct packed {
    logic ac;
    logic last;
    logic neg;
    logic pass;
  } stage_meta_t;

  // Last index of a block for a size code
  function automatic logic [9:0] last_index(input logic [1:0] tx);
    logic [9:0] r;
    case (tx)
      TX_4X4:   r = 10'd15;
      TX_8X8:   r = 10'd63;
      TX_16X16: r = 10'd255;
      TX_32X32: r = 10'd1023;
      default:  r = 10'd15;
    endcase
    return r;
  endfunction

  // Select the DC or AC half of a pair register
  function automatic logic signed [15:0] pick_half(input logic [31:0] pair, input logic ac);
    return ac ? $signed(pair[31:16]) : $signed(pair[15:0]);
  endfunction

endpackage

// File: src/transform_coeff_quant_dequant.sv
// Dead-zone quantizer with inverse quantizer for transform coefficients, one
// coefficient per transfer in scan order. A block holds 16, 64, 256 or 1024
// coefficients as set by tx_size; the first of a block uses the DC halves of
// the pair registers and the rest the AC halves. Each result carries the
// quantized level, its reconstructed value, the running nonzero count of the
// block and, on tlast, the end of the block. Sustained rate is one
// coefficient per cycle while the output is not stalled; an accepted input
// lands in the queue at its accepting edge and then passes the six
// registered stages of the back end (rounding, two chained quantizer
// multiplies, sign, the dequant multiply and saturation).
// A small queue sits between the front end, which tracks
// the position in the block, and the back end, so input and output can stall
// on their own. Write configuration only while no coefficient is in flight.
module transform_coeff_quant_dequant import tcqd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input coefficients
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] coefficient
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] quantized, [31:16] reconstructed,
                                  // [42:32] nonzero_count, [47:43] zero
  output logic        out_tlast,  // block_end
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;

  // Register file: always ready, unknown indexes dropped
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_TX_SIZE: cfg_nxt.tx_size      = cfg_data[1:0];
        REG_ZBIN:    cfg_nxt.zbin_pair    = cfg_data;
        REG_ROUND:   cfg_nxt.round_pair   = cfg_data;
        REG_QUANT:   cfg_nxt.quant_pair   = cfg_data;
        REG_SHIFT:   cfg_nxt.shift_pair   = cfg_data;
        REG_DEQUANT: cfg_nxt.dequant_pair = cfg_data;
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end to queue
  logic        push, pop, q_empty, q_full;
  queue_item_t push_item, head_item;

  tcqd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .tx_size    (cfg_r.tx_size),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .coef       ($signed(in_tdata)),
    .queue_full (q_full),
    .push       (push),
    .push_item  (push_item)
  );

  tcqd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Back end: arithmetic pipeline and output register
  logic signed [15:0] quantized, reconstructed;
  logic [10:0]        nonzero_count;

  tcqd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .queue_empty   (q_empty),
    .head_item     (head_item),
    .pop           (pop),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .quantized     (quantized),
    .reconstructed (reconstructed),
    .nonzero_count (nonzero_count),
    .block_end     (out_tlast)
  );

  // Pack the result fields, highest first
  assign out_tdata = {5'd0, nonzero_count, reconstructed, quantized};

endmodule

// File: src/tcqd_queue.sv
module tcqd_queue import tcqd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  queue_item_t push_item,
  input  logic        pop,
  output queue_item_t head_item,
  output logic        empty,
  output logic        full
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  queue_item_t      store [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign empty     = (fill_r == '0);
  assign full      = (fill_r == CNT_W'(DEPTH));
  assign head_item = store[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   fill_nxt = fill_r + 1'b1;
      2'b01:   fill_nxt = fill_r - 1'b1;
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: src/tcqd_front.sv
module tcqd_front import tcqd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         tx_size,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic signed [15:0] coef,
  input  logic               queue_full,
  output logic               push,
  output queue_item_t        push_item
);

  logic [9:0] position_r, position_nxt;
  logic       at_end;

  assign in_tready = !queue_full;
  assign push      = in_tvalid && !queue_full;
  assign at_end    = (position_r >= last_index(tx_size));

  assign push_item.coef = coef;
  assign push_item.ac   = (position_r != '0);
  assign push_item.last = at_end;

  always_comb begin
    position_nxt = position_r;
    if (push) begin
      position_nxt = at_end ? '0 : position_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
    end else begin
      position_r <= position_nxt;
    end
  end

endmodule

// File: src/tcqd_back.sv
module tcqd_back import tcqd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               queue_empty,
  input  queue_item_t        head_item,
  output logic               pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic signed [15:0] quantized,
  output logic signed [15:0] reconstructed,
  output logic [10:0]        nonzero_count,
  output logic               block_end
);

  logic big;
  logic adv;

  assign big = (cfg.tx_size == TX_32X32);
  // Whole pipeline moves together unless the output holds a result not yet taken
  assign adv = !out_tvalid || out_tready;
  assign pop = adv && !queue_empty;

  // Stage 1: magnitude, dead-zone test, rounding with clamp
  logic signed [16:0] c_ext, mag, zb_sel, rnd_sel;
  logic signed [17:0] t_sum;
  logic signed [15:0] t_clamp, zb_h, rnd_h;
  stage_meta_t        meta_in;

  always_comb begin
    zb_h    = pick_half(cfg.zbin_pair, head_item.ac);
    rnd_h   = pick_half(cfg.round_pair, head_item.ac);
    zb_sel  = 17'(zb_h);
    rnd_sel = 17'(rnd_h);
    if (big) begin
      zb_sel  = (zb_sel + 17'sd1) >>> 1;
      rnd_sel = (rnd_sel + 17'sd1) >>> 1;
    end
    c_ext = 17'(head_item.coef);
    mag   = head_item.coef[15] ? -c_ext : c_ext;
    t_sum = 18'(mag) + 18'(rnd_sel);
    if (t_sum < -18'sd32768) begin
      t_clamp = 16'sh8000;
    end else if (t_sum > 18'sd32767) begin
      t_clamp = 16'sh7fff;
    end else begin
      t_clamp = t_sum[15:0];
    end
    meta_in.ac   = head_item.ac;
    meta_in.last = head_item.last;
    meta_in.neg  = head_item.coef[15];
    meta_in.pass = (mag >= zb_sel);
  end

  logic               v1_r, v2_r, v3_r, v4_r, v5_r;
  stage_meta_t        m1_r, m2_r, m3_r, m4_r, m5_r;
  logic signed [15:0] t1_r, t2_r;
  logic signed [31:0] p1_r;
  logic signed [32:0] p2_r, p3_r;
  logic signed [15:0] level4_r;
  logic               nz4_r, nz5_r;
  logic signed [15:0] level5_r;

  // Stage 3 arithmetic: (t*q >> 16) + t, times shift
  logic signed [16:0] u_sum;
  logic signed [15:0] s_h, s_eff;
  always_comb begin
    u_sum = 17'($signed(p1_r[31:16])) + 17'(t2_r);
    s_h   = pick_half(cfg.shift_pair, m2_r.ac);
    s_eff = big ? $signed({s_h[14:0], 1'b0}) : s_h;
  end

  // Stage 4 arithmetic: final level and sign
  logic signed [16:0] t_fin;
  logic               nz_fin;
  logic [15:0]        lvl_fin;
  always_comb begin
    t_fin   = m3_r.pass ? $signed(p2_r[32:16]) : 17'sd0;
    nz_fin  = (t_fin != 17'sd0);
    lvl_fin = m3_r.neg ? 16'(17'sd0 - t_fin) : t_fin[15:0];
  end

  // Stage 5 arithmetic: dequant product on |level|
  logic signed [16:0] lvl_ext, lvl_mag;
  logic signed [15:0] scale_h;
  always_comb begin
    lvl_ext = 17'(level4_r);
    lvl_mag = level4_r[15] ? -lvl_ext : lvl_ext;
    scale_h = pick_half(cfg.dequant_pair, m4_r.ac);
  end

  // Output stage: halve at the largest size, sign, saturate, count
  logic signed [32:0] m_sh;
  logic signed [33:0] m_sgn;
  logic signed [15:0] m_sat;
  logic [10:0]        count_calc;
  logic [10:0]        running_r, running_nxt;
  always_comb begin
    m_sh  = big ? (p3_r >>> 1) : p3_r;
    m_sgn = level5_r[15] ? -34'(m_sh) : 34'(m_sh);
    if (m_sgn < -34'sd32768) begin
      m_sat = 16'sh8000;
    end else if (m_sgn > 34'sd32767) begin
      m_sat = 16'sh7fff;
    end else begin
      m_sat = m_sgn[15:0];
    end
    count_calc  = (m5_r.ac ? running_r : 11'd0) + {10'd0, nz5_r};
    running_nxt = running_r;
    if (adv && v5_r) begin
      running_nxt = m5_r.last ? 11'd0 : count_calc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      v4_r       <= 1'b0;
      v5_r       <= 1'b0;
      out_tvalid <= 1'b0;
      running_r  <= '0;
    end else begin
      running_r <= running_nxt;
      if (adv) begin
        v1_r       <= !queue_empty;
        v2_r       <= v1_r;
        v3_r       <= v2_r;
        v4_r       <= v3_r;
        v5_r       <= v4_r;
        out_tvalid <= v5_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r          <= meta_in;
      t1_r          <= t_clamp;
      m2_r          <= m1_r;
      t2_r          <= t1_r;
      p1_r          <= t1_r * pick_half(cfg.quant_pair, m1_r.ac);
      m3_r          <= m2_r;
      p2_r          <= u_sum * s_eff;
      m4_r          <= m3_r;
      level4_r      <= $signed(lvl_fin);
      nz4_r         <= nz_fin;
      m5_r          <= m4_r;
      level5_r      <= level4_r;
      nz5_r         <= nz4_r;
      p3_r          <= lvl_mag * scale_h;
      quantized     <= level5_r;
      reconstructed <= m_sat;
      nonzero_count <= count_calc;
      block_end     <= m5_r.last;
    end
  end

endmodule

// File: src/tcqd_checker.sv
`include "assert_macros.svh"

module tcqd_props (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tlast
);

  // A stalled result stays on offer unchanged
  `TCQD_ASSERT(hold_stalled,
               out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast),
               "stalled result changed")

  // The count never passes the largest block
  `TCQD_ASSERT_VALID(count_range, out_tdata[42:32] <= 11'd1024, "nonzero count out of range")

  // A zero level reconstructs to zero
  `TCQD_ASSERT_VALID(zero_recon,
                     (out_tdata[15:0] != 16'd0) || (out_tdata[31:16] == 16'd0),
                     "zero level with nonzero reconstruction")

  // Padding above the count stays clear
  `TCQD_ASSERT_VALID(pad_clear, out_tdata[47:43] == 5'd0, "padding bits set")

endmodule

bind transform_coeff_quant_dequant tcqd_props u_tcqd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
